// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/bsvm_pkg.sv -----
// Shared types and constants of the script VM core.
package bsvm_pkg;
	localparam int ADDR_W = 13;
	localparam int DATA_W = 32;
	localparam int DEF_VAR_COUNT = 16;
	localparam int DEF_PROGRAM_DEPTH = 4096;

	typedef enum logic [3:0] {
		ACT_CALL = 4'd0, ACT_RET = 4'd1, ACT_GPIO = 4'd2, ACT_SLEEP = 4'd3,
		ACT_PRINT = 4'd4, ACT_SET = 4'd5, ACT_MATH = 4'd6, ACT_JUMP = 4'd7,
		ACT_JIF = 4'd8, ACT_HALT = 4'd9
	} action_t;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;

	localparam logic [2:0] CC_EQ = 3'd0;
	localparam logic [2:0] CC_NE = 3'd1;
	localparam logic [2:0] CC_LT = 3'd2;
	localparam logic [2:0] CC_GT = 3'd3;
	localparam logic [2:0] CC_LE = 3'd4;
	localparam logic [2:0] CC_GE = 3'd5;

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_STACK = 2'd2;
	localparam logic [1:0] ST_END = 2'd3;

	localparam logic [1:0] FX_NONE = 2'd0;
	localparam logic [1:0] FX_GPIO = 2'd1;
	localparam logic [1:0] FX_SLEEP = 2'd2;
	localparam logic [1:0] FX_PRINT = 2'd3;

	localparam logic [0:0] REG_PROGRAM_LENGTH = 1'd0;

	typedef struct packed {
		logic start;
		logic cmp;
		logic [2:0] subop;
	} alu_cmd_t;

	typedef struct packed {
		logic done;
		logic [DATA_W-1:0] result;
		logic cond;
	} alu_rsp_t;
endpackage

// ----- rtl/bsvm_alu.sv -----
// Bit-serial math and compare unit: add/sub/compare and shift-add multiply and
// restoring divide, one bit per cycle.
module bsvm_alu
	import bsvm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  alu_cmd_t          cmd,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output alu_rsp_t          rsp
);
	`include "assert_macros.svh"

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] x_q, y_q, acc_q, res_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, carry_q, eq_q, done_q, neg_q, cond_q;
	logic [2:0]        op_q;
	logic              sa_q, sb_q, cmp_q;

	logic              xb, yb, sbit, cnext, ybit_eff;
	logic [DATA_W:0]   rem_try;
	logic [DATA_W-1:0] mag_a, mag_b;
	logic              last;
	logic              lt;
	logic              do_mul, do_div;

	assign mag_a = a[DATA_W-1] ? DATA_W'(-a) : a;
	assign mag_b = b[DATA_W-1] ? DATA_W'(-b) : b;
	assign xb = x_q[0];
	assign yb = y_q[0];
	assign do_mul = !cmp_q && (op_q == OP_MUL);
	assign do_div = !cmp_q && (op_q == OP_DIV);
	// add for add, else subtract (sub and compare)
	assign ybit_eff = (!cmp_q && op_q == OP_ADD) ? yb : ~yb;
	assign sbit = xb ^ ybit_eff ^ carry_q;
	assign cnext = (xb & ybit_eff) | (xb & carry_q) | (ybit_eff & carry_q);
	assign rem_try = {acc_q, x_q[DATA_W-1]} - {1'b0, y_q};
	assign last = (cnt_q == CNT_W'(DATA_W - 1));
	// signed a<b: sign of a-b corrected for overflow
	assign lt = (sa_q ^ sb_q) ? sa_q : sbit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				op_q <= cmd.subop;
				cmp_q <= cmd.cmp;
				sa_q <= a[DATA_W-1];
				sb_q <= b[DATA_W-1];
				eq_q <= 1'b1;
				acc_q <= '0;
				neg_q <= (a[DATA_W-1] ^ b[DATA_W-1]);
				carry_q <= cmd.cmp || (cmd.subop != OP_ADD);
				if (!cmd.cmp && cmd.subop == OP_DIV) begin
					x_q <= mag_a;
					y_q <= mag_b;
				end else begin
					x_q <= a;
					y_q <= b;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (do_mul) begin
					// shift-add: acc accumulates a << i when bit i of b is set
					if (y_q[0]) acc_q <= acc_q + x_q;
					x_q <= {x_q[DATA_W-2:0], 1'b0};
					y_q <= {1'b0, y_q[DATA_W-1:1]};
				end else if (do_div) begin
					x_q <= {x_q[DATA_W-2:0], ~rem_try[DATA_W]};
					if (!rem_try[DATA_W]) acc_q <= rem_try[DATA_W-1:0];
					else acc_q <= {acc_q[DATA_W-2:0], x_q[DATA_W-1]};
				end else begin
					carry_q <= cnext;
					eq_q <= eq_q & (xb == yb);
					x_q <= {1'b0, x_q[DATA_W-1:1]};
					y_q <= {1'b0, y_q[DATA_W-1:1]};
					acc_q <= {sbit, acc_q[DATA_W-1:1]};
				end
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					unique case (op_q)
						OP_ADD, OP_SUB: res_q <= {sbit, acc_q[DATA_W-1:1]};
						OP_MUL: res_q <= y_q[0] ? acc_q + x_q : acc_q;
						OP_DIV: begin
							if (y_q == '0) res_q <= '0;
							else if (neg_q) res_q <= -{x_q[DATA_W-2:0], ~rem_try[DATA_W]};
							else res_q <= {x_q[DATA_W-2:0], ~rem_try[DATA_W]};
						end
						default: res_q <= '0;
					endcase
					unique case (op_q)
						CC_EQ: cond_q <= eq_q & (xb == yb);
						CC_NE: cond_q <= !(eq_q & (xb == yb));
						CC_LT: cond_q <= lt;
						CC_GT: cond_q <= !lt && !(eq_q & (xb == yb));
						CC_LE: cond_q <= lt || (eq_q & (xb == yb));
						CC_GE: cond_q <= !lt;
						default: cond_q <= 1'b0;
					endcase
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.result = res_q;
	assign rsp.cond = cond_q;

	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q, "alu done held two cycles")
	`ASSERT_IMPL(a_no_restart, clk, arst_n, busy_q, !cmd.start, "alu started while busy")
	`ASSERT_IMPL(a_cnt_range, clk, arst_n, busy_q, cnt_q < CNT_W'(DATA_W), "alu count out of range")
endmodule

// ----- rtl/bytecode_script_vm_core.sv -----
// Script VM core top level: decode, variable file, return stack and control.
// Each instruction is accepted into the input register, executed and retired to
// the output register; math with a known subop and jump-if-false with a known
// condition first run through the bit-serial unit (start, wait for done, retire).
// One instruction at a time: no new instruction is taken until the last retires;
// a result left waiting on the output stalls the next retire.
// Reset clears the variables, pointer, stack depth and program length.
module bytecode_script_vm_core
	import bsvm_pkg::*;
#(
	parameter int VAR_COUNT = DEF_VAR_COUNT,
	parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// action[3:0], subop[6:4], dest_is_var[7], dest_index[15:8], a_is_var[16],
	// a_value[48:17], b_is_var[49], b_value[81:50], target_addr[94:82]
	input  logic [95:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// next_addr[12:0], run_status[14:13], effect_kind[16:15],
	// effect_first[48:17], effect_second[80:49]
	output logic [87:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	`include "assert_macros.svh"

	localparam int VI_W = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
	localparam int SD_W = $clog2(VAR_COUNT + 1);
	localparam int LEN_CLIP = (PROGRAM_DEPTH < 8191) ? PROGRAM_DEPTH : 8191;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_RETIRE} state_t;

	state_t state_q;
	logic [ADDR_W-1:0] plen_q, ip_q;
	logic [DATA_W-1:0] vars_q [VAR_COUNT];
	logic [ADDR_W-1:0] rstack [VAR_COUNT];
	logic [SD_W-1:0]   sd_q;
	logic [95:0]       in_q;
	logic [DATA_W-1:0] a_q, b_q;
	logic              ovf_q, res_full_q;
	logic [87:0]       res_q;

	logic [3:0] act;
	logic [2:0] sub;
	logic dvar;
	logic [7:0] didx;
	logic [ADDR_W-1:0] tgt;
	logic [DATA_W-1:0] a_raw, b_raw, a_op, b_op;
	logic [ADDR_W-1:0] len;
	alu_cmd_t alu_cmd;
	alu_rsp_t alu_rsp;

	assign act = in_q[3:0];
	assign sub = in_q[6:4];
	assign dvar = in_q[7];
	assign didx = in_q[15:8];
	assign tgt = in_q[94:82];
	assign a_raw = s_tdata[48:17];
	assign b_raw = s_tdata[81:50];
	assign len = (plen_q > ADDR_W'(LEN_CLIP)) ? ADDR_W'(LEN_CLIP) : plen_q;

	always_comb begin
		a_op = a_raw;
		if (s_tdata[16]) a_op = (a_raw < DATA_W'(VAR_COUNT)) ? vars_q[a_raw[VI_W-1:0]] : '0;
		b_op = b_raw;
		if (s_tdata[49]) b_op = (b_raw < DATA_W'(VAR_COUNT)) ? vars_q[b_raw[VI_W-1:0]] : '0;
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = res_full_q;
	assign m_tdata = res_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PROGRAM_LENGTH) ? {19'd0, plen_q} : '0;

	assign alu_cmd.start = (state_q == S_EXEC) &&
		((act == ACT_MATH && sub <= OP_DIV) || (act == ACT_JIF && sub <= CC_GE));
	assign alu_cmd.cmp = (act == ACT_JIF);
	assign alu_cmd.subop = sub;

	bsvm_alu u_alu (.clk, .arst_n, .cmd(alu_cmd), .a(a_q), .b(b_q), .rsp(alu_rsp));

	logic dest_ok;
	logic out_free;
	assign dest_ok = dvar && ({1'b0, didx} < 9'(VAR_COUNT));
	// the output register is free, or empties at this edge
	assign out_free = !res_full_q || m_tready;

	// return stack: written on call only, read below depth
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && out_free && act == ACT_CALL && !ovf_q &&
				sd_q < SD_W'(VAR_COUNT))
			rstack[sd_q[VI_W-1:0]] <= ip_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic [ADDR_W:0] nxt;
		logic [1:0] st, fk;
		logic [DATA_W-1:0] f1, f2;
		logic [SD_W-1:0] sd_n;
		logic res_load;
		if (!arst_n) begin
			state_q <= S_IDLE;
			plen_q <= '0;
			ip_q <= '0;
			sd_q <= '0;
			res_full_q <= 1'b0;
			for (int i = 0; i < VAR_COUNT; i++) vars_q[i] <= '0;
		end else begin
			nxt = '0; st = ST_RUN; fk = FX_NONE; f1 = '0; f2 = '0;
			sd_n = sd_q;
			res_load = 1'b0;
			if (psel && penable && pwrite && paddr[2] == REG_PROGRAM_LENGTH)
				plen_q <= pwdata[ADDR_W-1:0];
			unique case (state_q)
				S_IDLE: if (s_tvalid && s_tready) begin
					in_q <= s_tdata;
					a_q <= a_op;
					b_q <= b_op;
					ovf_q <= (ip_q >= len);
					state_q <= S_EXEC;
				end
				S_EXEC, S_RETIRE: if (alu_cmd.start) begin
					state_q <= S_WAIT;
				end else if (out_free) begin
					nxt = {1'b0, ip_q} + 1'b1;
					if (!ovf_q) begin
						unique case (act)
							ACT_CALL: if (sd_q < SD_W'(VAR_COUNT)) begin
								sd_n = sd_q + 1'b1;
								nxt = {1'b0, tgt};
							end else st = ST_STACK;
							ACT_RET: if (sd_q != '0) begin
								sd_n = sd_q - 1'b1;
								nxt = {1'b0, rstack[sd_n[VI_W-1:0]]} + 1'b1;
							end else st = ST_STACK;
							ACT_GPIO: begin fk = FX_GPIO; f1 = a_q; f2 = b_q; end
							ACT_SLEEP: begin fk = FX_SLEEP; f1 = a_q; end
							ACT_PRINT: begin fk = FX_PRINT; f1 = a_q; end
							ACT_SET: if (dest_ok) vars_q[didx[VI_W-1:0]] <= a_q;
							ACT_MATH: if (dest_ok) vars_q[didx[VI_W-1:0]] <=
								(state_q == S_RETIRE) ? alu_rsp.result : '0;
							ACT_JUMP: nxt = {1'b0, tgt};
							ACT_JIF: if (state_q != S_RETIRE || !alu_rsp.cond)
								nxt = {1'b0, tgt};
							ACT_HALT: st = ST_HALT;
							default: ;
						endcase
						if (st == ST_RUN && nxt >= {1'b0, len}) st = ST_END;
					end else st = ST_END;
					if (st != ST_RUN) begin
						ip_q <= '0;
						sd_n = '0;
						nxt = '0;
					end else ip_q <= nxt[ADDR_W-1:0];
					sd_q <= sd_n;
					res_q <= {7'd0, f2, f1, fk, st, nxt[ADDR_W-1:0]};
					res_load = 1'b1;
					state_q <= S_IDLE;
				end
				S_WAIT: if (alu_rsp.done) state_q <= S_RETIRE;
				default: state_q <= S_IDLE;
			endcase
			if (res_load) res_full_q <= 1'b1;
			else if (m_tvalid && m_tready) res_full_q <= 1'b0;
		end
	end

	`ASSERT_IMPL(a_depth_max, clk, arst_n, 1'b1, sd_q <= SD_W'(VAR_COUNT), "stack depth overflow")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
	`ASSERT_NEXT(a_exec_after_acc, clk, arst_n, s_tvalid && s_tready, state_q == S_EXEC, "no exec")
endmodule
